>>> rtl/core/ntce_pkg.sv
// Package: constants, codes and nibble-step helpers for the nibble table CRC engine.
package ntce_pkg;

  localparam int CRC_BITS  = 32;
  localparam int WIDTH_CAP = (CRC_BITS < 32) ? CRC_BITS : 32;
  localparam int NIB_W     = 4;
  localparam int TBL_DEPTH = 16;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int WORD_W    = 32;
  localparam int SEL_W     = 6;
  localparam int SH_W      = 5;

  localparam logic [0:0] FUNC_TABLE_WRITE = 1'b0;
  localparam logic [0:0] FUNC_BYTE        = 1'b1;

  localparam logic [0:0] REG_WIDTH_SEL   = 1'b0;
  localparam logic [0:0] REG_START_VALUE = 1'b1;

  localparam logic [SEL_W-1:0] SEL_REFLECTED  = '0;
  localparam logic [SEL_W-1:0] SEL_RESET      = SEL_W'(32);
  localparam logic [WORD_W-1:0] START_RESET   = '1;

  function automatic logic [SH_W-1:0] index_shift(logic [SEL_W-1:0] sel);
    logic [SEL_W-1:0] w;
    logic [SEL_W-1:0] d;
    w = sel;
    if (w < SEL_W'(NIB_W)) begin
      w = SEL_W'(NIB_W);
    end else if (w > SEL_W'(WIDTH_CAP)) begin
      w = SEL_W'(WIDTH_CAP);
    end
    d = w - SEL_W'(NIB_W);
    return d[SH_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] crc_shift(logic refl, logic [WORD_W-1:0] c);
    return refl ? (c >> NIB_W) : (c << NIB_W);
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_index(logic refl, logic [WORD_W-1:0] c,
                                                  logic [NIB_W-1:0] nib,
                                                  logic [SH_W-1:0] sh);
    logic [WORD_W-1:0] t;
    t = c >> sh;
    return refl ? (c[NIB_W-1:0] ^ nib) : (t[NIB_W-1:0] ^ nib);
  endfunction

endpackage

>>> rtl/core/nibble_table_crc_engine_top.sv
// Top level: nibble table CRC engine with table memory, two-step fold and output register.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata: addr, word, byte; tuser: func, first
//  m_axis    | out       | tvalid/tready          | tdata: crc_out; tlast fixed high
//  cfg       | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// A byte makes two dependent reads of the nibble table on its single read port; a new item
// can be taken in the cycle the second read returns. Table writes are stored when accepted.
// A last byte's CRC passes the first read, the second read and then the output register.
// Reset clears the CRC register and flags, sets width 32 and start all ones, keeps the table.
// A stalled output holds a finishing last byte and input until the result is taken.
module nibble_table_crc_engine_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [47:0]               s_axis_tdata,  // table_addr, table_word, in_byte, zero fill
  input  logic [1:0]                s_axis_tuser,  // func, first_byte
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // crc_out
  output logic                      m_axis_tlast,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import ntce_pkg::*;

  logic [SEL_W-1:0]  crc_width_sel;
  logic [WORD_W-1:0] start_value;
  logic [WORD_W-1:0] crc_reg;
  logic [WORD_W-1:0] c_reg;
  logic [7:0]        b_reg;
  logic              last_reg;
  logic              busy;
  logic              pend2;
  logic              out_valid;
  logic [WORD_W-1:0] out_data;

  logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
  logic [WORD_W-1:0] tbl_q;

  logic              refl;
  logic [SH_W-1:0]   sh;
  logic              in_fire;
  logic              byte_fire;
  logic              tbl_we;
  logic              stall2;
  logic              rd_en;
  logic [TBL_AW-1:0] rd_addr;
  logic [WORD_W-1:0] c_step;
  logic [WORD_W-1:0] crc_cur;
  logic [WORD_W-1:0] c0;
  logic [NIB_W-1:0]  in_nib;
  logic [NIB_W-1:0]  reg_nib;

  logic [3:0]        in_addr;
  logic [31:0]       in_word;
  logic [7:0]        in_byte;
  logic              in_func;
  logic              in_first;

  assign in_addr  = s_axis_tdata[3:0];
  assign in_word  = s_axis_tdata[35:4];
  assign in_byte  = s_axis_tdata[43:36];
  assign in_func  = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];

  assign refl = (crc_width_sel == SEL_REFLECTED);
  assign sh   = index_shift(crc_width_sel);

  assign stall2        = pend2 && last_reg && out_valid && !m_axis_tready;
  assign s_axis_tready = !busy && !stall2;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign byte_fire     = in_fire && (in_func == FUNC_BYTE);
  assign tbl_we        = in_fire && (in_func == FUNC_TABLE_WRITE);

  assign c_step  = tbl_q ^ crc_shift(refl, c_reg);
  assign crc_cur = pend2 ? c_step : crc_reg;
  assign c0      = in_first ? start_value : crc_cur;
  assign in_nib  = refl ? in_byte[3:0] : in_byte[7:4];
  assign reg_nib = refl ? b_reg[7:4] : b_reg[3:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = tbl_index(refl, c0, in_nib, sh);
    if (busy) begin
      rd_en   = 1'b1;
      rd_addr = tbl_index(refl, c_step, reg_nib, sh);
    end else if (byte_fire) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[in_addr] <= in_word;
    end
    if (rd_en) begin
      tbl_q <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width_sel <= SEL_RESET;
      start_value   <= START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH_SEL:   crc_width_sel <= cfg_data[SEL_W-1:0];
        REG_START_VALUE: start_value   <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pend2   <= 1'b0;
      crc_reg <= '0;
    end else begin
      if (busy) begin
        busy  <= 1'b0;
        pend2 <= 1'b1;
      end else begin
        if (pend2 && !stall2) begin
          crc_reg <= c_step;
          pend2   <= 1'b0;
        end
        if (byte_fire) begin
          busy <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      c_reg <= c_step;
    end else if (byte_fire) begin
      c_reg    <= c0;
      b_reg    <= in_byte;
      last_reg <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend2 && last_reg && !stall2) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend2 && last_reg && !stall2) begin
      out_data <= c_step;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = 1'b1;

  a_phase_order: assert property (@(posedge clk) disable iff (rst) busy |=> pend2)
    else $error("first table read not followed by second");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst) !(busy && pend2))
    else $error("both fold phases active");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (pend2 && last_reg && !stall2) |=> (m_axis_tvalid && m_axis_tdata == $past(c_step)))
    else $error("finished CRC not loaded into output register");

  a_crc_commit: assert property (@(posedge clk) disable iff (rst)
    (pend2 && !stall2) |=> (crc_reg == $past(c_step) || busy))
    else $error("CRC register not updated after fold");

endmodule
